FILE: src/csu_mix_pkg.sv
`timescale 1ns / 1ps
package csu_mix_pkg;

  typedef struct packed {
    logic        action;
    logic [4:0]  reg_offset;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [1:0]  duty;
    logic        halt;
    logic        cvol;
    logic [3:0]  vol;
    logic        sw_en;
    logic [2:0]  sw_per;
    logic        sw_neg;
    logic [2:0]  sw_shift;
    logic        sw_upd;
    logic [10:0] period;
    logic [7:0]  length;
    logic [3:0]  env_cnt;
    logic [4:0]  env_div;
    logic        env_upd;
    logic [3:0]  sw_cnt;
    logic [2:0]  pos;
    logic [10:0] timer;
    logic [12:0] level;
  } pulse_t;

  typedef struct packed {
    logic        halt;
    logic [6:0]  lin_load;
    logic [6:0]  lin;
    logic        reload;
    logic [7:0]  length;
    logic [4:0]  pos;
    logic [10:0] period;
    logic [10:0] timer;
    logic [12:0] level;
  } tri_t;

  typedef struct packed {
    logic        cvol;
    logic [3:0]  vol;
    logic [1:0]  mode;
    logic [3:0]  per;
    logic [7:0]  length;
    logic [3:0]  env;
    logic        env_wr;
    logic [10:0] timer;
    logic [14:0] lfsr;
    logic [12:0] level;
  } noise_t;

  localparam pulse_t PULSE_RST = '{sw_cnt: 4'd1, default: '0};
  localparam tri_t   TRI_RST   = '{default: '0};
  localparam noise_t NOISE_RST = '{lfsr: 15'd1, default: '0};

  localparam logic [4:0] REG_P0_CTRL  = 5'h00;
  localparam logic [4:0] REG_P0_SWEEP = 5'h01;
  localparam logic [4:0] REG_P0_LO    = 5'h02;
  localparam logic [4:0] REG_P0_HI    = 5'h03;
  localparam logic [4:0] REG_P1_CTRL  = 5'h04;
  localparam logic [4:0] REG_P1_SWEEP = 5'h05;
  localparam logic [4:0] REG_P1_LO    = 5'h06;
  localparam logic [4:0] REG_P1_HI    = 5'h07;
  localparam logic [4:0] REG_T_CTRL   = 5'h08;
  localparam logic [4:0] REG_T_LO     = 5'h0A;
  localparam logic [4:0] REG_T_HI     = 5'h0B;
  localparam logic [4:0] REG_N_CTRL   = 5'h0C;
  localparam logic [4:0] REG_N_MODE   = 5'h0E;
  localparam logic [4:0] REG_N_LEN    = 5'h0F;
  localparam logic [4:0] REG_ENABLE   = 5'h15;

  localparam logic [10:0] RATE_STEP  = 11'd261;
  localparam logic [10:0] RATE_MUL   = 11'd7;
  localparam logic [8:0]  TICK_BASE  = 9'd261;
  localparam logic [8:0]  TICK_HI    = 9'd266;
  localparam logic [8:0]  TICK_LO    = 9'd252;
  localparam logic [4:0]  TICKS_HI   = 5'd19;
  localparam logic [4:0]  TICKS_LO   = 5'd18;
  localparam logic [2:0]  MAX_SAMPLES = 3'd7;
  localparam logic [9:0]  STEP120    = 10'd400;
  localparam logic [8:0]  STEP240    = 9'd200;
  localparam logic [27:0] DC_KEEP    = 28'd4064;
  localparam int          DIV_BITS   = 21;

  function automatic logic [7:0] len_tab(input logic [4:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
      5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
      5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
      5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
      5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
      5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
      5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
      5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
    endcase
    return r;
  endfunction

  localparam logic [31:0] DUTY_BITS = 32'b11111001_00011110_00000110_00000010;

  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] pos);
    return DUTY_BITS[{duty, pos}];
  endfunction

  // half of the noise timer period
  function automatic logic [10:0] noise_half(input logic [3:0] p);
    logic [10:0] r;
    unique case (p)
      4'd0: r = 11'd2;    4'd1: r = 11'd4;    4'd2: r = 11'd8;    4'd3: r = 11'd16;
      4'd4: r = 11'd32;   4'd5: r = 11'd48;   4'd6: r = 11'd64;   4'd7: r = 11'd80;
      4'd8: r = 11'd101;  4'd9: r = 11'd127;  4'd10: r = 11'd190; 4'd11: r = 11'd254;
      4'd12: r = 11'd381; 4'd13: r = 11'd508; 4'd14: r = 11'd1017; default: r = 11'd2034;
    endcase
    return r;
  endfunction

  // (5000 * gain) >> 4
  function automatic logic [12:0] noise_amp(input logic [3:0] g);
    logic [12:0] r;
    unique case (g)
      4'd0: r = 13'd0;     4'd1: r = 13'd312;   4'd2: r = 13'd625;   4'd3: r = 13'd937;
      4'd4: r = 13'd1250;  4'd5: r = 13'd1562;  4'd6: r = 13'd1875;  4'd7: r = 13'd2187;
      4'd8: r = 13'd2500;  4'd9: r = 13'd2812;  4'd10: r = 13'd3125; 4'd11: r = 13'd3437;
      4'd12: r = 13'd3750; 4'd13: r = 13'd4062; 4'd14: r = 13'd4375; default: r = 13'd4687;
    endcase
    return r;
  endfunction

endpackage

FILE: src/console_sound_unit_mixer_unit.sv
`timescale 1ns / 1ps
// Sound unit mixer: two pulse, one triangle and one noise voice, mixed to 48 kHz.
// Input channel (in_valid_i / in_stall_o / in_item_i): a transaction is either a
// register write (action 0) or an advance in time by the amount given in the item (action 1).
// A write is applied in the idle state and yields nothing. An advance yields zero to
// seven samples on the output channel (out_valid_o / out_stall_i / out_item_o);
// last marks the final sample of that advance.
// Each sample goes through a rate and frame step, a setup step, the tick steps
// (all voices step together), then a pass of the shared restoring divider for
// each voice that is sounding (a silent voice is passed over), and DC tracking
// and output load. in_stall_o stays high throughout an advance item.
// A sample sits in the output register until taken; while out_stall_i is high
// the sequencer holds and no further work is done.
// Reset clears all voice state (sweep counters to one, noise LFSR to one), the
// frame counters, rate accumulators and the DC tracker.
module console_sound_unit_mixer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csu_mix_pkg::in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csu_mix_pkg::out_t out_item_o
);
  import csu_mix_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_TICK   = 4'd3;
  localparam logic [3:0] S_DIVSEL = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DCS    = 4'd6;
  localparam logic [3:0] S_OUTS   = 4'd7;
  localparam logic [3:0] S_WAIT   = 4'd8;

  logic [3:0]  state_q, state_d;
  pulse_t      pulse_q [2];
  pulse_t      pulse_d [2];
  tri_t        tri_q, tri_d;
  noise_t      noise_q, noise_d;
  logic [3:0]  en_q, en_d;
  logic [8:0]  f120_q, f120_d;
  logic [7:0]  f240_q, f240_d;
  logic [10:0] acc_q, acc_d;
  logic [3:0]  rem_q, rem_d;
  logic [4:0]  ticks_q, ticks_d;
  logic [4:0]  tcnt_q, tcnt_d;
  logic [2:0]  n_q, n_d;
  logic [3:0]  act_q, act_d;
  logic [12:0] pass_q, pass_d;
  logic [20:0] sum_q [4];
  logic [20:0] sum_d [4];
  logic [1:0]  ch_q, ch_d;
  logic [4:0]  drem_q, drem_d;
  logic [20:0] quo_q, quo_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [15:0] mix_q, mix_d;
  logic [15:0] dc_q, dc_d;
  logic [15:0] vol_q, vol_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  always_comb begin
    logic        c_sel;
    logic [3:0]  cnt;
    logic [11:0] delta;
    logic signed [12:0] tgt;
    logic [8:0]  rsum;
    logic [3:0]  g;
    logic [3:0]  idx;
    logic        fb;
    logic [5:0]  trial;
    logic        qbit;
    logic [27:0] prod;
    logic        adv;

    c_sel = in_item_i.reg_offset[2];
    cnt = '0; delta = '0; tgt = '0; rsum = '0; g = '0; idx = '0; fb = 1'b0;
    trial = '0; qbit = 1'b0; prod = '0; adv = 1'b0;

    state_d = state_q;
    pulse_d = pulse_q;
    tri_d = tri_q;
    noise_d = noise_q;
    en_d = en_q;
    f120_d = f120_q;
    f240_d = f240_q;
    acc_d = acc_q;
    rem_d = rem_q;
    ticks_d = ticks_q;
    tcnt_d = tcnt_q;
    n_d = n_q;
    act_d = act_q;
    pass_d = pass_q;
    sum_d = sum_q;
    ch_d = ch_q;
    drem_d = drem_q;
    quo_d = quo_q;
    dcnt_d = dcnt_q;
    mix_d = mix_q;
    dc_d = dc_q;
    vol_d = vol_q;
    out_valid_d = out_valid_q;
    out_d = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_item_i.action) begin
            unique case (in_item_i.reg_offset)
              REG_P0_CTRL, REG_P1_CTRL: begin
                pulse_d[c_sel].duty = in_item_i.data[7:6];
                pulse_d[c_sel].halt = in_item_i.data[5];
                pulse_d[c_sel].cvol = in_item_i.data[4];
                pulse_d[c_sel].vol  = in_item_i.data[3:0];
              end
              REG_P0_SWEEP, REG_P1_SWEEP: begin
                pulse_d[c_sel].sw_en    = in_item_i.data[7];
                pulse_d[c_sel].sw_per   = in_item_i.data[6:4];
                pulse_d[c_sel].sw_neg   = in_item_i.data[3];
                pulse_d[c_sel].sw_shift = in_item_i.data[2:0];
                pulse_d[c_sel].sw_upd   = 1'b1;
              end
              REG_P0_LO, REG_P1_LO: pulse_d[c_sel].period[7:0] = in_item_i.data;
              REG_P0_HI, REG_P1_HI: begin
                pulse_d[c_sel].period[10:8] = in_item_i.data[2:0];
                pulse_d[c_sel].length = len_tab(in_item_i.data[7:3]);
                pulse_d[c_sel].env_upd = 1'b1;
              end
              REG_T_CTRL: begin
                tri_d.halt = in_item_i.data[7];
                tri_d.lin_load = in_item_i.data[6:0];
              end
              REG_T_LO: tri_d.period[7:0] = in_item_i.data;
              REG_T_HI: begin
                tri_d.period[10:8] = in_item_i.data[2:0];
                tri_d.length = len_tab(in_item_i.data[7:3]);
                tri_d.reload = 1'b1;
              end
              REG_N_CTRL: begin
                noise_d.cvol = in_item_i.data[4];
                noise_d.vol = in_item_i.data[3:0];
                noise_d.mode[1] = in_item_i.data[5];
              end
              REG_N_MODE: begin
                noise_d.mode[0] = in_item_i.data[7];
                noise_d.per = in_item_i.data[3:0];
              end
              REG_N_LEN: begin
                noise_d.length = len_tab(in_item_i.data[7:3]);
                noise_d.env_wr = 1'b1;
              end
              REG_ENABLE: en_d = in_item_i.data[3:0];
              default: ;
            endcase
          end else begin
            acc_d = acc_q + {3'b0, in_item_i.cycles} * RATE_MUL;
            n_d = '0;
            state_d = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (acc_q >= RATE_STEP && n_q < MAX_SAMPLES) begin
          acc_d = acc_q - RATE_STEP;
          n_d = n_q + 3'd1;
          rsum = {5'b0, rem_q} + TICK_BASE;
          if (rsum >= TICK_HI) begin
            ticks_d = TICKS_HI;
            rem_d = 4'(rsum - TICK_HI);
          end else begin
            ticks_d = TICKS_LO;
            rem_d = 4'(rsum - TICK_LO);
          end
          // 120 Hz step
          if ({1'b0, f120_q} + 10'd1 >= STEP120) begin
            f120_d = '0;
            for (int c = 0; c < 2; c++) begin
              if (!pulse_d[c[0]].halt && pulse_d[c[0]].length != 8'd0)
                pulse_d[c[0]].length = pulse_d[c[0]].length - 8'd1;
              if (pulse_d[c[0]].sw_en) begin
                cnt = (pulse_d[c[0]].sw_cnt != 4'd0) ? pulse_d[c[0]].sw_cnt - 4'd1 : 4'd0;
                if (cnt == 4'd0) begin
                  cnt = {1'b0, pulse_d[c[0]].sw_per} + 4'd1;
                  delta = {1'b0, pulse_d[c[0]].period >> pulse_d[c[0]].sw_shift}
                        + {11'b0, (c == 0) && pulse_d[c[0]].sw_neg};
                  tgt = pulse_d[c[0]].sw_neg
                      ? $signed({2'b0, pulse_d[c[0]].period}) - $signed({1'b0, delta})
                      : $signed({2'b0, pulse_d[c[0]].period}) + $signed({1'b0, delta});
                  if (pulse_d[c[0]].period >= 11'd8 && tgt < 13'sd2048 &&
                      pulse_d[c[0]].sw_shift != 3'd0)
                    pulse_d[c[0]].period = (tgt < 13'sd0) ? 11'd0 : tgt[10:0];
                end
                pulse_d[c[0]].sw_cnt = cnt;
              end
              if (pulse_d[c[0]].sw_upd) begin
                pulse_d[c[0]].sw_cnt = {1'b0, pulse_d[c[0]].sw_per} + 4'd1;
                pulse_d[c[0]].sw_upd = 1'b0;
              end
            end
            if (tri_d.reload) tri_d.lin = tri_d.lin_load;
            if (!tri_d.halt) begin
              if (tri_d.length != 8'd0) tri_d.length = tri_d.length - 8'd1;
              if (tri_d.lin != 7'd0) tri_d.lin = tri_d.lin - 7'd1;
              tri_d.reload = 1'b0;
            end
            if (noise_d.env_wr) begin
              noise_d.env_wr = 1'b0;
              noise_d.env = 4'd15;
            end
            if (noise_d.mode[1] && noise_d.env == 4'd0) noise_d.env = 4'd15;
            else if (noise_d.env != 4'd0) noise_d.env = noise_d.env - 4'd1;
          end else begin
            f120_d = f120_q + 9'd1;
          end
          // 240 Hz step
          if ({1'b0, f240_q} + 9'd1 >= STEP240) begin
            f240_d = '0;
            for (int c = 0; c < 2; c++) begin
              if (pulse_d[c[0]].env_upd) begin
                pulse_d[c[0]].env_upd = 1'b0;
                pulse_d[c[0]].env_cnt = 4'd15;
                pulse_d[c[0]].env_div = 5'd0;
              end else begin
                pulse_d[c[0]].env_div = pulse_d[c[0]].env_div + 5'd1;
                if (pulse_d[c[0]].env_div > {1'b0, pulse_d[c[0]].vol}) begin
                  pulse_d[c[0]].env_div = 5'd0;
                  if (pulse_d[c[0]].halt && pulse_d[c[0]].env_cnt == 4'd0)
                    pulse_d[c[0]].env_cnt = 4'd15;
                  else if (pulse_d[c[0]].env_cnt != 4'd0)
                    pulse_d[c[0]].env_cnt = pulse_d[c[0]].env_cnt - 4'd1;
                end
              end
            end
          end else begin
            f240_d = f240_q + 8'd1;
          end
          state_d = S_PREP;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_PREP: begin
        for (int c = 0; c < 2; c++) begin
          act_d[c] = en_q[c] && pulse_q[c[0]].period >= 11'd8 &&
                     pulse_q[c[0]].length != 8'd0 &&
                     !(pulse_q[c[0]].cvol && pulse_q[c[0]].vol == 4'd0);
          if (en_q[c] && !act_d[c]) pulse_d[c[0]].level = '0;
        end
        act_d[2] = en_q[2] && tri_q.length != 8'd0 && tri_q.lin != 7'd0 &&
                   tri_q.period >= 11'd2;
        pass_d = (en_q[2] && !act_d[2]) ? tri_q.level : 13'd0;
        act_d[3] = en_q[3] && noise_q.length != 8'd0 &&
                   (noise_q.cvol ? noise_q.vol != 4'd0 : noise_q.env != 4'd0);
        if (en_q[3] && !act_d[3]) noise_d.level = '0;
        for (int k = 0; k < 4; k++) sum_d[k] = '0;
        tcnt_d = '0;
        mix_d = '0;
        ch_d = '0;
        state_d = S_TICK;
      end

      S_TICK: begin
        for (int c = 0; c < 2; c++) begin
          if (act_q[c]) begin
            if (pulse_q[c[0]].timer == 11'd0) begin
              pulse_d[c[0]].pos = pulse_q[c[0]].pos + 3'd1;
              pulse_d[c[0]].timer = pulse_q[c[0]].period;
              g = pulse_q[c[0]].cvol ? pulse_q[c[0]].vol : pulse_q[c[0]].env_cnt;
              pulse_d[c[0]].level = duty_bit(pulse_q[c[0]].duty, pulse_d[c[0]].pos)
                                  ? {g, 9'b0} : 13'd0;
            end else begin
              pulse_d[c[0]].timer = pulse_q[c[0]].timer - 11'd1;
              sum_d[c] = sum_q[c] + {8'b0, pulse_q[c[0]].level};
            end
          end
        end
        if (act_q[2]) begin
          if (tri_q.timer == 11'd0) begin
            tri_d.pos = tri_q.pos + 5'd1;
            tri_d.timer = tri_q.period;
            idx = tri_d.pos[4] ? ~tri_d.pos[3:0] : tri_d.pos[3:0];
            tri_d.level = {idx, 9'b0};
          end else begin
            tri_d.timer = tri_q.timer - 11'd1;
          end
          sum_d[2] = sum_q[2] + {8'b0, tri_d.level};
        end
        if (act_q[3]) begin
          if (noise_q.timer == 11'd0) begin
            noise_d.timer = noise_half(noise_q.per);
            fb = noise_q.mode[0] ? (noise_q.lfsr[8] ^ noise_q.lfsr[14])
                                 : (noise_q.lfsr[13] ^ noise_q.lfsr[14]);
            noise_d.lfsr = {noise_q.lfsr[13:0], fb};
            noise_d.level = noise_d.lfsr[14]
                          ? noise_amp(noise_q.cvol ? noise_q.vol : noise_q.env) : 13'd0;
          end else begin
            noise_d.timer = noise_q.timer - 11'd1;
          end
          sum_d[3] = sum_q[3] + {8'b0, noise_d.level};
        end
        tcnt_d = tcnt_q + 5'd1;
        if (tcnt_q == ticks_q - 5'd1) state_d = S_DIVSEL;
      end

      S_DIVSEL: begin
        if (act_q[ch_q]) begin
          drem_d = '0;
          quo_d = sum_q[ch_q];
          dcnt_d = '0;
          state_d = S_DIV;
        end else begin
          if (ch_q == 2'd2) mix_d = mix_q + {3'b0, pass_q};
          adv = 1'b1;
        end
      end

      S_DIV: begin
        // one quotient bit per cycle
        trial = {drem_q, quo_q[DIV_BITS-1]};
        qbit = trial >= {1'b0, ticks_q};
        drem_d = qbit ? 5'(trial - {1'b0, ticks_q}) : trial[4:0];
        quo_d = {quo_q[DIV_BITS-2:0], qbit};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'(DIV_BITS - 1)) begin
          mix_d = mix_q + quo_d[15:0];
          adv = 1'b1;
        end
      end

      S_DCS: begin
        vol_d = {mix_q[14:0], 1'b0};
        prod = {12'b0, dc_q} * DC_KEEP + {7'b0, vol_d, 5'b0};
        dc_d = prod[27:12];
      end

      S_OUTS: begin
        out_d.sample = $signed(vol_q - dc_q);
        out_d.last = !(acc_q >= RATE_STEP && n_q < MAX_SAMPLES);
        out_valid_d = 1'b1;
        state_d = S_WAIT;
      end

      S_WAIT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d = S_CHECK;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // advance to the next voice or finish the mix
    if (adv) begin
      if (ch_q == 2'd3) state_d = S_DCS;
      else begin
        ch_d = ch_q + 2'd1;
        state_d = S_DIVSEL;
      end
    end
    if (state_q == S_DCS) state_d = S_OUTS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pulse_q[0] <= PULSE_RST;
      pulse_q[1] <= PULSE_RST;
      tri_q <= TRI_RST;
      noise_q <= NOISE_RST;
      en_q <= '0;
      f120_q <= '0;
      f240_q <= '0;
      acc_q <= '0;
      rem_q <= '0;
      ticks_q <= TICKS_LO;
      tcnt_q <= '0;
      n_q <= '0;
      act_q <= '0;
      pass_q <= '0;
      for (int k = 0; k < 4; k++) sum_q[k] <= '0;
      ch_q <= '0;
      drem_q <= '0;
      quo_q <= '0;
      dcnt_q <= '0;
      mix_q <= '0;
      dc_q <= '0;
      vol_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      pulse_q <= pulse_d;
      tri_q <= tri_d;
      noise_q <= noise_d;
      en_q <= en_d;
      f120_q <= f120_d;
      f240_q <= f240_d;
      acc_q <= acc_d;
      rem_q <= rem_d;
      ticks_q <= ticks_d;
      tcnt_q <= tcnt_d;
      n_q <= n_d;
      act_q <= act_d;
      pass_q <= pass_d;
      sum_q <= sum_d;
      ch_q <= ch_d;
      drem_q <= drem_d;
      quo_q <= quo_d;
      dcnt_q <= dcnt_d;
      mix_q <= mix_d;
      dc_q <= dc_d;
      vol_q <= vol_d;
      out_valid_q <= out_valid_d;
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while a sample is pending");

  a_ticks_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK || state_q == S_DIV) |-> (ticks_q == TICKS_LO || ticks_q == TICKS_HI))
    else $error("tick count out of range");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < 4'd14) else $error("tick remainder out of range");

  a_idle_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (acc_q < RATE_STEP)) else $error("rate backlog left at idle");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_item_o.last) |=> (state_q == S_CHECK) ##1
    (state_q == S_IDLE)) else $error("samples continue after last");

endmodule
